// ===== sv/complex_wavelet_magnitude_filter_macros.svh =====
// Assertion macros for the wavelet magnitude filter checker.
// The macros expect a signal named clock, and CWM_ASSERT_IMPL also reset, in the calling scope.
`ifndef COMPLEX_WAVELET_MAGNITUDE_FILTER_MACROS_SVH
`define COMPLEX_WAVELET_MAGNITUDE_FILTER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CWM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a condition on every clock edge, reset included.
`define CWM_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) (cond)) \
      else $error("assertion failed");

`endif

// ===== sv/cwm_pkg.sv =====
// Shared types and constants for the wavelet magnitude filter.
// No dependencies; the front end, back end, top, checkers and testbench import it.
package cwm_pkg;

   localparam int SAMPLE_BITS = 16;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_PUSH   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic CSR_TAP_COUNT    = 1'b0;
   localparam logic CSR_RESULT_SHIFT = 1'b1;

   localparam logic [8:0] TAP_COUNT_RESET    = 9'd256;
   localparam logic [4:0] RESULT_SHIFT_RESET = 5'd15;

   typedef struct packed {
      logic [1:0]                    action;
      logic [7:0]                    tap_index;
      logic signed [15:0]            tap_real;
      logic signed [15:0]            tap_imag;
      logic signed [SAMPLE_BITS-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [31:0] magnitude;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic [8:0] tap_count;
      logic [4:0] result_shift;
   } cfg_type;

endpackage

// ===== sv/cwm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/cwm_front.sv =====
// Front end: accepts request transfers, drops those with no effect, and
// queues the rest in a two-entry FIFO. Depends on cwm_pkg.
module cwm_front #(
   parameter int MAX_TAPS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cwm_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cwm_pkg::req_type cmd_data
);
   import cwm_pkg::*;

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep, push, pop;

   // classify: keep pushes, clears and in-range loads
   always_comb begin
      case (req_data.action)
         ACT_LOAD:            keep = int'(req_data.tap_index) < MAX_TAPS;
         ACT_PUSH, ACT_CLEAR: keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   assign req_ready = count_ff != 2'd2;
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = count_ff != 2'd0;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store queued entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end
endmodule

// ===== sv/cwm_isqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// No dependencies.
module cwm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);
   logic [63:0] x_ff, x_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] rem_sh, trial;

   // one restoring step per cycle
   always_comb begin
      rem_sh  = {rem_ff[32:0], x_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[61:0], 2'b00};
         cnt_in = cnt_ff - 6'd1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         busy_in = cnt_ff != 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

// ===== sv/cwm_back.sv =====
// Back end: tap and history memories, complex multiply-accumulate sequencer,
// scaling, squaring and square root. Depends on cwm_pkg, cwm_ram, cwm_isqrt.
module cwm_back #(
   parameter int MAX_TAPS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  cwm_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cwm_pkg::req_type cmd_data,
   output logic             res_valid,
   input  logic             res_ready,
   output cwm_pkg::rsp_type res_data
);
   import cwm_pkg::*;

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int CW    = $clog2(MAX_TAPS + 1);
   localparam int PW    = 16 + SAMPLE_BITS;
   localparam int ACC_W = PW + AW;
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MAC    = 8'b0000_0010,
      S_DRAIN  = 8'b0000_0100,
      S_SCALE  = 8'b0000_1000,
      S_SQUARE = 8'b0001_0000,
      S_SUM    = 8'b0010_0000,
      S_ROOT   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in, haddr_ff, haddr_in, head_new;
   logic [CW-1:0] fill_ff, fill_in, n_ff, n_in, issue_ff, issue_in, n_cfg;
   logic          p1_ff, p1_in, live_ff, live_in, p2_ff;
   logic signed [PW-1:0]    prod_re_ff, prod_im_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, sh_re, sh_im;
   logic signed [31:0]      re_ff, im_ff, re_sat, im_sat;
   logic                    flag_ff, flag_in;
   logic [31:0]             mag_re, mag_im;
   logic [63:0]             sq_re_ff, sq_im_ff;
   logic [15:0]             tr_rd, ti_rd;
   logic [SAMPLE_BITS-1:0]  hist_rd, hist_use;
   logic tap_we, hist_we, is_cmd, sq_start, sq_busy;
   logic [31:0] sq_root;

   assign cmd_ready = state_ff == S_IDLE;
   assign is_cmd    = cmd_valid && cmd_ready;
   assign tap_we    = is_cmd && cmd_data.action == ACT_LOAD;
   assign hist_we   = is_cmd && cmd_data.action == ACT_PUSH;
   assign head_new  = (head_ff == '0) ? AW'(MAX_TAPS - 1) : head_ff - AW'(1);
   assign n_cfg     = (int'(cfg.tap_count) > MAX_TAPS) ? CW'(MAX_TAPS)
                                                       : CW'(cfg.tap_count);

   cwm_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_real (
      .clock(clock), .we(tap_we), .waddr(AW'(cmd_data.tap_index)),
      .wdata(cmd_data.tap_real), .raddr(issue_ff[AW-1:0]), .rdata(tr_rd));
   cwm_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_imag (
      .clock(clock), .we(tap_we), .waddr(AW'(cmd_data.tap_index)),
      .wdata(cmd_data.tap_imag), .raddr(issue_ff[AW-1:0]), .rdata(ti_rd));
   cwm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist (
      .clock(clock), .we(hist_we), .waddr(head_new),
      .wdata(cmd_data.sample_value), .raddr(haddr_ff), .rdata(hist_rd));

   // sequencer
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      issue_in = issue_ff;
      haddr_in = haddr_ff;
      p1_in    = 1'b0;
      live_in  = 1'b0;
      sq_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (is_cmd && cmd_data.action == ACT_CLEAR) begin
               fill_in = '0;
            end
            if (hist_we) begin
               head_in  = head_new;
               haddr_in = head_new;
               fill_in  = (fill_ff == CW'(MAX_TAPS)) ? fill_ff : fill_ff + CW'(1);
               n_in     = n_cfg;
               issue_in = '0;
               state_in = (n_cfg == '0) ? S_SCALE : S_MAC;
            end
         end
         S_MAC: begin
            p1_in    = 1'b1;
            live_in  = issue_ff < fill_ff;
            issue_in = issue_ff + CW'(1);
            haddr_in = (haddr_ff == AW'(MAX_TAPS - 1)) ? '0 : haddr_ff + AW'(1);
            if (issue_ff == n_ff - CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:  if (!p1_ff && !p2_ff) state_in = S_SCALE;
         S_SCALE:  state_in = S_SQUARE;
         S_SQUARE: state_in = S_SUM;
         S_SUM: begin
            sq_start = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT:   if (!sq_busy) state_in = S_DONE;
         S_DONE:   if (res_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         p1_ff    <= 1'b0;
         p2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         p1_ff    <= p1_in;
         p2_ff    <= p1_ff;
      end
   end

   // mask history entries older than the fill count
   assign hist_use = live_ff ? hist_rd : '0;

   // multiply, accumulate, then scale, saturate and take absolute values
   always_comb begin
      sh_re   = acc_re_ff >>> cfg.result_shift;
      sh_im   = acc_im_ff >>> cfg.result_shift;
      flag_in = 1'b0;
      re_sat  = 32'(sh_re);
      im_sat  = 32'(sh_im);
      if (sh_re > SAT_HI) begin
         re_sat = 32'sh7FFF_FFFF; flag_in = 1'b1;
      end else if (sh_re < SAT_LO) begin
         re_sat = 32'sh8000_0000; flag_in = 1'b1;
      end
      if (sh_im > SAT_HI) begin
         im_sat = 32'sh7FFF_FFFF; flag_in = 1'b1;
      end else if (sh_im < SAT_LO) begin
         im_sat = 32'sh8000_0000; flag_in = 1'b1;
      end
      mag_re = re_ff[31] ? 32'(~re_ff) + 32'd1 : 32'(re_ff);
      mag_im = im_ff[31] ? 32'(~im_ff) + 32'd1 : 32'(im_ff);
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      issue_ff <= issue_in;
      haddr_ff <= haddr_in;
      live_ff  <= live_in;
      prod_re_ff <= $signed(tr_rd) * $signed(hist_use);
      prod_im_ff <= $signed(ti_rd) * $signed(hist_use);
      if (hist_we) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (p2_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
      if (state_ff == S_SCALE) begin
         re_ff   <= re_sat;
         im_ff   <= im_sat;
         flag_ff <= flag_in;
      end
      if (state_ff == S_SQUARE) begin
         sq_re_ff <= mag_re * mag_re;
         sq_im_ff <= mag_im * mag_im;
      end
   end

   cwm_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand(sq_re_ff + sq_im_ff), .busy(sq_busy), .root(sq_root));

   assign res_valid          = state_ff == S_DONE;
   assign res_data.magnitude = sq_root;
   assign res_data.saturated = flag_ff;
endmodule

// ===== sv/complex_wavelet_magnitude_filter.sv =====
// A load or clear takes effect when the back end accepts it; a push runs
// min(tap_count, MAX_TAPS) taps through the one shared
// complex multiply-accumulate (one tap per cycle) and the 32-step square root.
// Pushes do not overlap in the back end; the two-entry queue and output
// register let requests and responses stall independently.
// Reset (synchronous, active high) empties the history and the queue.
module complex_wavelet_magnitude_filter #(
   parameter int MAX_TAPS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cwm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cwm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [8:0]       csr_wdata
);
   import cwm_pkg::*;

   cfg_type cfg_ff;
   req_type cmd_data;
   rsp_type res_data, rsp_data_ff;
   logic    cmd_valid, cmd_ready, res_valid, res_ready, rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_count    <= TAP_COUNT_RESET;
         cfg_ff.result_shift <= RESULT_SHIFT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAP_COUNT:    cfg_ff.tap_count    <= csr_wdata;
            CSR_RESULT_SHIFT: cfg_ff.result_shift <= csr_wdata[4:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   cwm_front #(.MAX_TAPS(MAX_TAPS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data));

   cwm_back #(.MAX_TAPS(MAX_TAPS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready), .cmd_data(cmd_data), .res_valid(res_valid),
      .res_ready(res_ready), .res_data(res_data));

   // output register: hold until transfer
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== sv/cwm_checker.sv =====
// Port-level checker for the wavelet magnitude filter, bound to the top.
// Depends on cwm_pkg and the assertion macro header.
`include "complex_wavelet_magnitude_filter_macros.svh"

module cwm_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cwm_pkg::rsp_type rsp_data
);
   import cwm_pkg::*;

   // a stalled response stays valid
   `CWM_ASSERT_IMPL(a_rsp_hold, $past(rsp_valid && !rsp_ready), rsp_valid)
   // magnitude cannot exceed sqrt(2) * 2^31
   `CWM_ASSERT_IMPL(a_mag_bound, rsp_valid, rsp_data.magnitude <= 32'hB504_F333)
   // reset drops any pending response
   `CWM_ASSERT_ALWAYS(a_reset_clear, !$past(reset) || !rsp_valid)
endmodule

bind complex_wavelet_magnitude_filter cwm_port_checker u_cwm_checker (.*);

// ===== test/cwm_checker.sv =====
// Checker for the wavelet magnitude filter: watches request, response and CSR traffic.
// Predicts each push result and compares it in order; depends on cwm_pkg only.
module cwm_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cwm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cwm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [8:0]       csr_wdata,
   output int               outstanding,
   output int               failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import cwm_pkg::*;

   localparam int DEPTH = 256;

   logic signed [15:0]            coef_re [DEPTH];
   logic signed [15:0]            coef_im [DEPTH];
   logic signed [SAMPLE_BITS-1:0] history [DEPTH];
   logic [8:0]                    taps_used;
   logic [4:0]                    sum_shift;
   rsp_type                       expected_q [$];

   initial begin
      outstanding = 0;
      failures    = 0;
   end

   // Floor square root, one result bit per pair of operand bits.
   function automatic logic [31:0] floor_root(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] probe;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= root + probe) begin
            x    = x - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[31:0];
   endfunction

   // Scale one sum and clip it to signed 32 bits.
   function automatic logic signed [63:0] scale_clip(logic signed [63:0] sum, ref logic clipped);
      logic signed [63:0] scaled;
      scaled = sum >>> sum_shift;
      if (scaled > 64'sd2147483647) begin
         clipped = 1'b1;
         scaled  = 64'sd2147483647;
      end else if (scaled < -64'sd2147483648) begin
         clipped = 1'b1;
         scaled  = -64'sd2147483648;
      end
      return scaled;
   endfunction

   // Shift a sample into the history and compute the filtered magnitude.
   function automatic rsp_type filter_sample(logic signed [SAMPLE_BITS-1:0] sample);
      rsp_type            result;
      logic signed [63:0] sum_re;
      logic signed [63:0] sum_im;
      logic signed [63:0] part_re;
      logic signed [63:0] part_im;
      logic [63:0]        mag_re;
      logic [63:0]        mag_im;
      logic               clipped;
      int                 span;
      for (int d = DEPTH - 1; d > 0; d--) history[d] = history[d-1];
      history[0] = sample;
      span   = (taps_used > DEPTH) ? DEPTH : taps_used;
      sum_re = '0;
      sum_im = '0;
      for (int d = 0; d < span; d++) begin
         sum_re = sum_re + coef_re[d] * history[d];
         sum_im = sum_im + coef_im[d] * history[d];
      end
      clipped = 1'b0;
      part_re = scale_clip(sum_re, clipped);
      part_im = scale_clip(sum_im, clipped);
      mag_re  = (part_re < 0) ? -part_re : part_re;
      mag_im  = (part_im < 0) ? -part_im : part_im;
      result.magnitude = floor_root(mag_re * mag_re + mag_im * mag_im);
      result.saturated = clipped;
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         taps_used = TAP_COUNT_RESET;
         sum_shift = RESULT_SHIFT_RESET;
         for (int d = 0; d < DEPTH; d++) begin
            history[d] = '0;
            coef_re[d] = '0;
            coef_im[d] = '0;
         end
         expected_q.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            if (csr_index == CSR_TAP_COUNT) taps_used = csr_wdata;
            else sum_shift = csr_wdata[4:0];
         end
         // predict on each accepted request
         if (req_valid && req_ready) begin
            case (req_data.action)
               ACT_LOAD: begin
                  coef_re[req_data.tap_index] = req_data.tap_real;
                  coef_im[req_data.tap_index] = req_data.tap_imag;
               end
               ACT_PUSH: expected_q.push_back(filter_sample(req_data.sample_value));
               ACT_CLEAR: for (int d = 0; d < DEPTH; d++) history[d] = '0;
               default: ;
            endcase
         end
         // compare each response transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected response: magnitude %0d saturated %0b",
                      rsp_data.magnitude, rsp_data.saturated);
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.magnitude !== want.magnitude) begin
                  $error("magnitude: expected %0d, actual %0d",
                         want.magnitude, rsp_data.magnitude);
                  failures++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         want.saturated, rsp_data.saturated);
                  failures++;
               end
            end
         end
      end
      outstanding = expected_q.size();
   end
endmodule

// ===== test/complex_wavelet_magnitude_filter_tb.sv =====
// Top of the wavelet magnitude filter testbench: clock, reset, stimulus and verdict.
// Depends on cwm_pkg, the filter RTL and cwm_checker.
module complex_wavelet_magnitude_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cwm_pkg::*;

   localparam int RANDOM_ITEMS = 670;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 320;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = CSR_TAP_COUNT;
   logic [8:0] csr_wdata = '0;
   int      outstanding;
   int      failures;
   int      cycle_count = 0;
   bit      calm = 1'b0;
   bit      hold_request = 1'b0;

   always #5 clock = ~clock;

   complex_wavelet_magnitude_filter u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   cwm_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .outstanding, .failures
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 26);
            @(posedge clock);
         end
      end
   end

   // Bias a Q1.15 value toward its extremes.
   function automatic logic [15:0] pick_q15();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one request and hold it until the transfer.
   task automatic send(logic [1:0] action, logic [7:0] index, logic [15:0] re_val,
                       logic [15:0] im_val, logic [15:0] sample);
      req_type item;
      item.action       = action;
      item.tap_index    = index;
      item.tap_real     = re_val;
      item.tap_imag     = im_val;
      item.sample_value = sample;
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drain, let trailing loads settle, then write one register.
   task automatic write_csr(logic index, logic [8:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random();
      int roll;
      roll = $urandom_range(99);
      if (roll < 62)
         send(ACT_PUSH, 8'($urandom()), 16'($urandom()), 16'($urandom()), pick_q15());
      else if (roll < 82)
         send(ACT_LOAD, 8'($urandom()), pick_q15(), pick_q15(), 16'($urandom()));
      else
         send(ACT_CLEAR, 8'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()));
   endtask

   initial begin
      int sent;
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every tap so no push ever reads an unwritten one.
      for (int d = 0; d < 256; d++) send(ACT_LOAD, 8'(d), pick_q15(), pick_q15(), '0);

      // Directed: extreme taps and samples, clear, ignored action, zero tap count.
      send(ACT_LOAD, 8'd0, 16'h7fff, 16'h8000, 16'h0000);
      send(ACT_LOAD, 8'd255, 16'h8000, 16'h7fff, 16'hffff);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h7fff);
      send(ACT_PUSH, 8'hff, 16'hffff, 16'hffff, 16'h8000);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send(ACT_UNUSED, 8'hff, 16'hffff, 16'hffff, 16'hffff);
      send(ACT_CLEAR, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);
      write_csr(CSR_RESULT_SHIFT, 9'd0);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h7fff);
      write_csr(CSR_RESULT_SHIFT, 9'd31);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);
      write_csr(CSR_TAP_COUNT, 9'd0);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h7fff);
      write_csr(CSR_TAP_COUNT, 9'd511);
      write_csr(CSR_RESULT_SHIFT, 9'd0);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);
      write_csr(CSR_TAP_COUNT, 9'd1);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);
      send(ACT_LOAD, 8'd0, 16'h8000, 16'h8000, 16'h0000);
      send(ACT_PUSH, 8'd0, 16'h0000, 16'h0000, 16'h8000);

      // Random phases, each under its own register setting.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 8)
            0: write_csr(CSR_TAP_COUNT, 9'd256);
            1: write_csr(CSR_TAP_COUNT, 9'($urandom_range(1, 12)));
            3: write_csr(CSR_TAP_COUNT, 9'd511);
            5: write_csr(CSR_TAP_COUNT, 9'd0);
            default: write_csr(CSR_TAP_COUNT, 9'($urandom_range(1, 24)));
         endcase
         case ($urandom_range(3))
            0: write_csr(CSR_RESULT_SHIFT, 9'd0);
            1: write_csr(CSR_RESULT_SHIFT, 9'd31);
            default: write_csr(CSR_RESULT_SHIFT, 9'($urandom_range(0, 31)));
         endcase
         calm = (phase == 4);
         for (int k = 0; k < 95 && sent < RANDOM_ITEMS; k++) begin
            if (phase == 2 && k == 10) hold_request = 1'b1;
            if ($urandom_range(49) == 0)
               send(ACT_UNUSED, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom()));
            else begin
               send_random();
               sent++;
            end
         end
         phase++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Wait out the last results.
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
